[hdl/ptgc_pkg.sv]
// shared types and constants of the path token grammar checker
// token, status and update codes, queue entry and result records
// no dependencies
package ptgc_pkg;

  localparam int MAX_STEPS = 64;
  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int IDX_W = (STEP_W > 6) ? STEP_W : 6;
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_STEPS);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] FIFO_FULL_CNT = CNT_W'(FIFO_DEPTH);

  typedef enum logic [4:0] {
    TK_END      = 5'd0,
    TK_NAME     = 5'd1,
    TK_AXIS     = 5'd2,
    TK_NODENAME = 5'd3,
    TK_LPAREN   = 5'd4,
    TK_RPAREN   = 5'd5,
    TK_LBRACKET = 5'd6,
    TK_RBRACKET = 5'd7,
    TK_AT       = 5'd8,
    TK_DCOLON   = 5'd9,
    TK_DSLASH   = 5'd10,
    TK_SLASH    = 5'd11,
    TK_LITERAL  = 5'd12,
    TK_EQ       = 5'd13,
    TK_NEQ      = 5'd14,
    TK_UNSUP    = 5'd15,
    TK_IGNORED  = 5'd16,
    TK_NONE     = 5'd31
  } tok_t;

  typedef enum logic [1:0] {
    AX_CHILD = 2'd0,
    AX_ATTR  = 2'd1,
    AX_DESC  = 2'd2,
    AX_OTHER = 2'd3
  } axis_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD     = 3'd1,
    ST_NOTSUP  = 3'd2,
    ST_NOTTERM = 3'd3,
    ST_NOTIMPL = 3'd4,
    ST_NOROOM  = 3'd5,
    ST_SKIP    = 3'd6,
    ST_SYNTAX  = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    UPD_NONE       = 4'd0,
    UPD_STEP_NAME  = 4'd1,
    UPD_STEP_ATTR  = 4'd2,
    UPD_STEP_REL   = 4'd3,
    UPD_STEP_NODE  = 4'd4,
    UPD_PRED_NEW   = 4'd5,
    UPD_PRED_NAME  = 4'd6,
    UPD_PRED_ATTR  = 4'd7,
    UPD_PRED_OP    = 4'd8,
    UPD_PRED_VALUE = 4'd9
  } upd_t;

  typedef enum logic [1:0] {
    CMP_NONE = 2'd0,
    CMP_EQ   = 2'd1,
    CMP_NE   = 2'd2
  } cmp_t;

  typedef struct packed {
    tok_t        kind;
    axis_t       axis;
    logic        is_text;
    logic [15:0] toff;
    logic [7:0]  tlen;
    logic [15:0] lit_off;
    logic [7:0]  lit_len;
    logic        last;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic        new_step;
    logic [5:0]  step_index;
    upd_t        upd;
    cmp_t        op;
    logic [15:0] roff;
    logic [7:0]  rlen;
    logic        done;
  } result_t;

endpackage

[hdl/ptgc_front.sv]
// front end: classifies an incoming token into a queue entry
// folds unknown kinds into unsupported, precomputes the unquoted literal span
// depends on ptgc_pkg
module ptgc_front (
  input  logic [4:0]      token_kind,
  input  logic [1:0]      axis_kind,
  input  logic            is_text_name,
  input  logic [15:0]     text_offset,
  input  logic [7:0]      text_len,
  input  logic            last_token,
  output ptgc_pkg::entry_t entry
);
  import ptgc_pkg::*;

  always_comb begin
    if (token_kind <= 5'd16) begin
      entry.kind = tok_t'(token_kind);
    end else begin
      entry.kind = TK_UNSUP;
    end
    entry.axis    = axis_t'(axis_kind);
    entry.is_text = is_text_name;
    entry.toff    = text_offset;
    entry.tlen    = text_len;
    entry.lit_off = text_offset + 16'd1;
    entry.lit_len = (text_len >= 8'd2) ? (text_len - 8'd2) : 8'd0;
    entry.last    = last_token;
  end

endmodule

[hdl/ptgc_fifo.sv]
// short queue of classified tokens between front and back end
// depth from the package, registered pointers and fill count
// depends on ptgc_pkg
module ptgc_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  ptgc_pkg::entry_t wr_data,
  input  logic             rd,
  output ptgc_pkg::entry_t rd_data,
  output logic             full,
  output logic             nonempty
);
  import ptgc_pkg::*;

  entry_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FIFO_FULL_CNT);
  assign nonempty = (count != '0);
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_FULL_CNT) else $error("queue fill count beyond depth");

  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    wr && !rd |=> count == $past(count) + 1'b1) else $error("queue count lost a write");

endmodule

[hdl/ptgc_back.sv]
// back end: grammar state and per-token decision, result register
// takes a queue entry whenever the result register is free or being popped
// depends on ptgc_pkg
module ptgc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ptgc_pkg::entry_t  in_e,
  output logic              take,
  input  logic              pop,
  output logic              empty,
  output ptgc_pkg::result_t res
);
  import ptgc_pkg::*;

  tok_t              prev;
  logic              in_pred;
  logic              pred_attr;
  logic [STEP_W-1:0] step_count;
  logic              error_seen;
  logic              out_valid;

  tok_t              prev_next;
  logic              in_pred_next;
  logic              pred_attr_next;
  logic [STEP_W-1:0] step_count_next;
  logic              error_seen_next;
  result_t           res_next;

  logic              room;
  logic              name_ok;
  logic              axis_ok;
  logic              slash_ok;
  status_t           st;
  logic              ns;
  upd_t              upd;
  cmp_t              op;
  logic [15:0]       roff;
  logic [7:0]        rlen;
  logic [STEP_W-1:0] cnt_upd;
  logic [STEP_W-1:0] cnt_m1;
  logic [IDX_W-1:0]  idx_w;

  assign empty = !out_valid;
  assign take  = in_valid && (!out_valid || pop);

  assign room     = (step_count != STEP_MAX);
  assign name_ok  = (prev == TK_AT) || (prev == TK_AXIS) || (prev == TK_DCOLON) ||
                    (prev == TK_NONE) || (prev == TK_SLASH) || (prev == TK_DSLASH);
  assign axis_ok  = (prev == TK_LBRACKET) || (prev == TK_DSLASH) ||
                    (prev == TK_NONE) || (prev == TK_SLASH);
  assign slash_ok = (prev == TK_RBRACKET) || (prev == TK_NAME) || (prev == TK_NONE);

  always_comb begin
    st             = ST_OK;
    ns             = 1'b0;
    upd            = UPD_NONE;
    op             = CMP_NONE;
    roff           = '0;
    rlen           = '0;
    cnt_upd        = step_count;
    in_pred_next   = in_pred;
    pred_attr_next = pred_attr;
    prev_next      = prev;
    if (error_seen) begin
      st = ST_SKIP;
    end else begin
      case (in_e.kind)
        TK_END: begin
          if (!((prev == TK_NAME) || (prev == TK_RBRACKET) || (prev == TK_RPAREN))) begin
            st = ST_NOTTERM;
          end else if (in_pred) begin
            st = ST_SYNTAX;
          end
        end
        TK_NAME: begin
          if (!name_ok) begin
            st = ST_NOTSUP;
          end else if (in_pred) begin
            if (!pred_attr) begin
              st = ST_NOTIMPL;
            end else begin
              upd  = UPD_PRED_NAME;
              roff = in_e.toff;
              rlen = in_e.tlen;
            end
          end else if (prev == TK_NONE && !room) begin
            st = ST_NOROOM;
          end else begin
            if (prev == TK_NONE) begin
              ns      = 1'b1;
              cnt_upd = step_count + 1'b1;
            end
            upd  = UPD_STEP_NAME;
            roff = in_e.toff;
            rlen = in_e.tlen;
          end
        end
        TK_AXIS: begin
          if (!axis_ok) begin
            st = ST_BAD;
          end else if (in_e.axis == AX_OTHER) begin
            st = ST_NOTSUP;
          end else if (in_pred) begin
            if (in_e.axis != AX_ATTR) begin
              st = ST_NOTSUP;
            end else begin
              pred_attr_next = 1'b1;
              upd            = UPD_PRED_ATTR;
            end
          end else if (prev == TK_NONE && !room) begin
            st = ST_NOROOM;
          end else begin
            if (prev == TK_NONE) begin
              ns      = 1'b1;
              cnt_upd = step_count + 1'b1;
            end
            if (in_e.axis == AX_ATTR) begin
              upd = UPD_STEP_ATTR;
            end else if (in_e.axis == AX_DESC) begin
              upd = UPD_STEP_REL;
            end
          end
        end
        TK_NODENAME: begin
          if (in_pred || !name_ok || !in_e.is_text) begin
            st = ST_NOTSUP;
          end else if (prev == TK_NONE && !room) begin
            st = ST_NOROOM;
          end else begin
            if (prev == TK_NONE) begin
              ns      = 1'b1;
              cnt_upd = step_count + 1'b1;
            end
            upd  = UPD_STEP_NODE;
            roff = in_e.toff;
            rlen = in_e.tlen;
          end
        end
        TK_LPAREN: begin
          if (prev != TK_NODENAME) begin
            st = ST_BAD;
          end
        end
        TK_RPAREN: begin
          if (prev != TK_LPAREN) begin
            st = ST_NOTSUP;
          end
        end
        TK_LBRACKET: begin
          if (in_pred) begin
            st = ST_NOTSUP;
          end else if (prev != TK_NAME) begin
            st = ST_BAD;
          end else begin
            in_pred_next   = 1'b1;
            pred_attr_next = 1'b0;
            upd            = UPD_PRED_NEW;
          end
        end
        TK_RBRACKET: begin
          if (!in_pred) begin
            st = ST_NOTSUP;
          end else if (prev != TK_LITERAL) begin
            st = ST_BAD;
          end else begin
            in_pred_next = 1'b0;
          end
        end
        TK_AT: begin
          if (!axis_ok) begin
            st = ST_BAD;
          end else if (in_pred) begin
            pred_attr_next = 1'b1;
            upd            = UPD_PRED_ATTR;
          end else if (prev == TK_NONE && !room) begin
            st = ST_NOROOM;
          end else begin
            if (prev == TK_NONE) begin
              ns      = 1'b1;
              cnt_upd = step_count + 1'b1;
            end
            upd = UPD_STEP_ATTR;
          end
        end
        TK_DCOLON: begin
          if (!((prev == TK_AT) || (prev == TK_AXIS))) begin
            st = ST_BAD;
          end
        end
        TK_DSLASH, TK_SLASH: begin
          if (in_pred || !slash_ok) begin
            st = ST_NOTSUP;
          end else if (!room) begin
            st = ST_NOROOM;
          end else begin
            ns      = 1'b1;
            cnt_upd = step_count + 1'b1;
            if (in_e.kind == TK_DSLASH) begin
              upd = UPD_STEP_REL;
            end
          end
        end
        TK_LITERAL: begin
          if (in_pred && ((prev == TK_EQ) || (prev == TK_NEQ))) begin
            upd  = UPD_PRED_VALUE;
            roff = in_e.lit_off;
            rlen = in_e.lit_len;
          end else begin
            st = ST_NOTSUP;
          end
        end
        TK_EQ, TK_NEQ: begin
          if (in_pred && prev == TK_NAME) begin
            upd = UPD_PRED_OP;
            op  = (in_e.kind == TK_EQ) ? CMP_EQ : CMP_NE;
          end else begin
            st = ST_NOTSUP;
          end
        end
        TK_IGNORED: begin
          st = ST_OK;
        end
        default: begin
          st = ST_NOTSUP;
        end
      endcase
      if (st != ST_OK) begin
        ns             = 1'b0;
        upd            = UPD_NONE;
        op             = CMP_NONE;
        roff           = '0;
        rlen           = '0;
        cnt_upd        = step_count;
        in_pred_next   = in_pred;
        pred_attr_next = pred_attr;
      end
      prev_next = in_e.kind;
    end
  end

  // step index is the count after this token minus one
  always_comb begin
    cnt_m1 = (cnt_upd != '0) ? (cnt_upd - 1'b1) : '0;
    idx_w  = IDX_W'(cnt_m1);
    res_next.status     = st;
    res_next.new_step   = ns;
    res_next.step_index = idx_w[5:0];
    res_next.upd        = upd;
    res_next.op         = op;
    res_next.roff       = roff;
    res_next.rlen       = rlen;
    res_next.done       = in_e.last;
  end

  always_comb begin
    error_seen_next = error_seen || (st != ST_OK && st != ST_SKIP);
    step_count_next = cnt_upd;
    if (in_e.last) begin
      error_seen_next = 1'b0;
      step_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev       <= TK_NONE;
      in_pred    <= 1'b0;
      pred_attr  <= 1'b0;
      step_count <= '0;
      error_seen <= 1'b0;
    end else if (take) begin
      error_seen <= error_seen_next;
      step_count <= step_count_next;
      if (in_e.last) begin
        prev      <= TK_NONE;
        in_pred   <= 1'b0;
        pred_attr <= 1'b0;
      end else begin
        prev      <= prev_next;
        in_pred   <= in_pred_next;
        pred_attr <= pred_attr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    take && in_e.last |=> step_count == '0 && !error_seen && !in_pred && prev == TK_NONE)
    else $error("state not cleared after last token");

  a_skip_after_error: assert property (@(posedge clk) disable iff (rst)
    take && error_seen |=> res.status == ST_SKIP && res.upd == UPD_NONE)
    else $error("token after error not skipped");

  a_error_no_update: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.status != ST_OK |-> res.upd == UPD_NONE && !res.new_step)
    else $error("failed token carries an update");

endmodule

[hdl/path_token_grammar_checker_top.sv]
// Path token grammar checker, top level. Tokens of one path expression are
// pushed at up to one per clock while full is low; each yields exactly one
// result, in order. A token is classified on entry and written into a four-entry
// queue; the back end takes one entry per cycle while the result register is free
// or being popped, makes the grammar decision against the previous token and the
// predicate mode combinationally and holds the result in an output register.
// With pop held high a token passes the queue and then the output register, and
// the sustained rate is one token per cycle, set by the grammar update in the
// back end. Up to five results can wait while the result side stalls; full
// rises when the queue holds four entries. No clearing pass runs after reset.
// depends on ptgc_pkg, ptgc_front, ptgc_fifo, ptgc_back
module path_token_grammar_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  token_kind,
  input  logic [1:0]  axis_kind,
  input  logic        is_text_name,
  input  logic [15:0] text_offset,
  input  logic [7:0]  text_len,
  input  logic        last_token,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic        new_step,
  output logic [5:0]  step_index,
  output logic [3:0]  update_kind,
  output logic [1:0]  compare_op,
  output logic [15:0] ref_offset,
  output logic [7:0]  ref_len,
  output logic        expr_done
);
  import ptgc_pkg::*;

  entry_t  front_e;
  entry_t  q_e;
  logic    q_nonempty;
  logic    take;
  logic    wr;
  result_t res;

  assign wr = push && !full;

  ptgc_front u_front (
    .token_kind   (token_kind),
    .axis_kind    (axis_kind),
    .is_text_name (is_text_name),
    .text_offset  (text_offset),
    .text_len     (text_len),
    .last_token   (last_token),
    .entry        (front_e)
  );

  ptgc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .wr_data  (front_e),
    .rd       (take),
    .rd_data  (q_e),
    .full     (full),
    .nonempty (q_nonempty)
  );

  ptgc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_nonempty),
    .in_e     (q_e),
    .take     (take),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  assign status      = res.status;
  assign new_step    = res.new_step;
  assign step_index  = res.step_index;
  assign update_kind = res.upd;
  assign compare_op  = res.op;
  assign ref_offset  = res.roff;
  assign ref_len     = res.rlen;
  assign expr_done   = res.done;

endmodule
